FILE: hdl/lfs_pkg.sv
// Shared types and constants of the LED fade stepper.
`default_nettype none

package lfs_pkg;

    localparam int STRAND_LEN_W = 5;
    localparam logic [STRAND_LEN_W-1:0] STRAND_LEN_RESET = 5'd16;

    localparam logic REQ_SET  = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef struct packed {
        logic tgt_wr;
        logic commit;
        logic emit_final;
    } t_dp_cmd;

    typedef struct packed {
        logic changed;
        logic pend_valid;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

FILE: hdl/lfs_ctrl.sv
// Controller that walks the LEDs on a tick and sequences the datapath.
`default_nettype none

module lfs_ctrl import lfs_pkg::*; #(
    parameter int MAX_LEDS = 16,
    localparam int IDX_W = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output      logic                    o_stall,
    input  wire logic                    i_req_type,
    input  wire logic [3:0]              i_led_index,
    input  wire logic                    i_cfg_wr_en,
    input  wire logic [STRAND_LEN_W-1:0] i_cfg_wr_data,
    input  wire t_dp_status              i_status,
    output      t_dp_cmd                 o_cmd,
    output      logic [IDX_W-1:0]        o_rd_addr
);

    localparam int CNT_W = $clog2(MAX_LEDS + 1);
    localparam int LIM_W = (CNT_W > STRAND_LEN_W) ? CNT_W : STRAND_LEN_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_CALC  = 2'd2;
    localparam logic [1:0] S_FINAL = 2'd3;

    logic [1:0]              r_state, n_state;
    logic [IDX_W-1:0]        r_idx, n_idx;
    logic [LIM_W-1:0]        r_limit, n_limit;
    logic [STRAND_LEN_W-1:0] r_strand_len;
    logic [LIM_W-1:0]        tick_limit;
    logic                    idx_is_last;

    assign tick_limit = (LIM_W'(r_strand_len) > LIM_W'(MAX_LEDS)) ?
                        LIM_W'(MAX_LEDS) : LIM_W'(r_strand_len);
    assign idx_is_last = (LIM_W'(r_idx) + LIM_W'(1)) == r_limit;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_limit = r_limit;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_req_type == REQ_TICK) begin
                        n_limit = tick_limit;
                        n_idx   = '0;
                        n_state = (tick_limit == '0) ? S_FINAL : S_READ;
                    end else if (32'(i_led_index) < MAX_LEDS) begin
                        o_cmd.tgt_wr = 1'b1;
                    end
                end
            end
            S_READ: begin
                n_state = S_CALC;
            end
            S_CALC: begin
                if (!i_status.changed || !i_status.pend_valid || i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    if (idx_is_last) begin
                        n_state = S_FINAL;
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = S_READ;
                    end
                end
            end
            S_FINAL: begin
                if (i_status.out_free) begin
                    o_cmd.emit_final = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_limit      <= '0;
            r_strand_len <= STRAND_LEN_RESET;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_limit <= n_limit;
            if (i_cfg_wr_en) begin
                r_strand_len <= i_cfg_wr_data;
            end
        end
    end

    assign o_stall   = (r_state != S_IDLE);
    assign o_rd_addr = r_idx;

endmodule

`default_nettype wire

FILE: hdl/lfs_datapath.sv
// Level and target memories, channel step logic, pending word and output register.
`default_nettype none

module lfs_datapath import lfs_pkg::*; #(
    parameter int MAX_LEDS = 16,
    localparam int IDX_W = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_dp_cmd          i_cmd,
    output      t_dp_status       o_status,
    input  wire logic [IDX_W-1:0] i_rd_addr,
    input  wire logic [3:0]       i_led_index,
    input  wire logic [7:0]       i_target_red,
    input  wire logic [7:0]       i_target_green,
    input  wire logic [7:0]       i_target_blue,
    output      logic             o_valid,
    input  wire logic             i_stall,
    output      logic             o_pixel_valid,
    output      logic [3:0]       o_pixel_index,
    output      logic [7:0]       o_pixel_red,
    output      logic [7:0]       o_pixel_green,
    output      logic [7:0]       o_pixel_blue,
    output      logic             o_fade_done,
    output      logic             o_last
);

    // Quotient of an 8-bit level by 31, exact for the whole range.
    function automatic logic [3:0] div_by_31(input logic [7:0] c);
        logic [16:0] prod;
        begin
            prod = 17'(c) * 17'd265;
            return prod[16:13];
        end
    endfunction

    function automatic logic [7:0] step_channel(input logic [7:0] c, input logic [7:0] t);
        logic [3:0] inc;
        logic [8:0] sum;
        logic [7:0] diff;
        begin
            inc  = div_by_31(c) + 4'd1;
            sum  = 9'(c) + 9'(inc);
            diff = c - 8'(inc);
            if (c == t) begin
                return c;
            end else if (c < t) begin
                return (sum > 9'(t)) ? t : sum[7:0];
            end else if ((8'(inc) > c) || (diff < t)) begin
                return t;
            end else begin
                return c - 8'({1'b0, inc[3:1]} + 4'd1);
            end
        end
    endfunction

    logic [23:0]         r_tgt_mem [MAX_LEDS];
    logic [23:0]         r_cur_mem [MAX_LEDS];
    logic [MAX_LEDS-1:0] r_tgt_vld;
    logic [MAX_LEDS-1:0] r_cur_vld;
    logic [23:0]         r_tgt_rd;
    logic [23:0]         r_cur_rd;
    logic                r_tgt_rd_vld;
    logic                r_cur_rd_vld;

    logic [23:0] cur_lvl;
    logic [23:0] tgt_lvl;
    logic [23:0] new_lvl;
    logic        changed;
    logic        out_free;

    logic        r_pend_valid;
    logic [3:0]  r_pend_index;
    logic [23:0] r_pend_lvl;

    logic        r_o_valid;
    logic        r_o_pixel_valid;
    logic [3:0]  r_o_pixel_index;
    logic [23:0] r_o_lvl;
    logic        r_o_fade_done;
    logic        r_o_last;

    logic [IDX_W-1:0] tgt_wr_addr;

    assign tgt_wr_addr = IDX_W'(i_led_index);

    always_ff @(posedge i_clk) begin
        if (i_cmd.tgt_wr) begin
            r_tgt_mem[tgt_wr_addr] <= {i_target_red, i_target_green, i_target_blue};
        end
        r_tgt_rd <= r_tgt_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && changed) begin
            r_cur_mem[i_rd_addr] <= new_lvl;
        end
        r_cur_rd <= r_cur_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tgt_vld    <= '0;
            r_cur_vld    <= '0;
            r_tgt_rd_vld <= 1'b0;
            r_cur_rd_vld <= 1'b0;
        end else begin
            if (i_cmd.tgt_wr) begin
                r_tgt_vld[tgt_wr_addr] <= 1'b1;
            end
            if (i_cmd.commit && changed) begin
                r_cur_vld[i_rd_addr] <= 1'b1;
            end
            r_tgt_rd_vld <= r_tgt_vld[i_rd_addr];
            r_cur_rd_vld <= r_cur_vld[i_rd_addr];
        end
    end

    assign cur_lvl = r_cur_rd_vld ? r_cur_rd : '0;
    assign tgt_lvl = r_tgt_rd_vld ? r_tgt_rd : '0;

    assign new_lvl[23:16] = step_channel(cur_lvl[23:16], tgt_lvl[23:16]);
    assign new_lvl[15:8]  = step_channel(cur_lvl[15:8],  tgt_lvl[15:8]);
    assign new_lvl[7:0]   = step_channel(cur_lvl[7:0],   tgt_lvl[7:0]);
    assign changed        = (cur_lvl != tgt_lvl);
    assign out_free       = !r_o_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (i_cmd.commit && changed) begin
            r_pend_valid <= 1'b1;
        end else if (i_cmd.emit_final) begin
            r_pend_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && changed) begin
            r_pend_index <= 4'(i_rd_addr);
            r_pend_lvl   <= new_lvl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if ((i_cmd.commit && changed && r_pend_valid) || i_cmd.emit_final) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && changed && r_pend_valid) begin
            r_o_pixel_valid <= 1'b1;
            r_o_pixel_index <= r_pend_index;
            r_o_lvl         <= r_pend_lvl;
            r_o_fade_done   <= 1'b0;
            r_o_last        <= 1'b0;
        end else if (i_cmd.emit_final) begin
            r_o_last <= 1'b1;
            if (r_pend_valid) begin
                r_o_pixel_valid <= 1'b1;
                r_o_pixel_index <= r_pend_index;
                r_o_lvl         <= r_pend_lvl;
                r_o_fade_done   <= 1'b0;
            end else begin
                r_o_pixel_valid <= 1'b0;
                r_o_pixel_index <= '0;
                r_o_lvl         <= '0;
                r_o_fade_done   <= 1'b1;
            end
        end
    end

    assign o_status.changed    = changed;
    assign o_status.pend_valid = r_pend_valid;
    assign o_status.out_free   = out_free;

    assign o_valid       = r_o_valid;
    assign o_pixel_valid = r_o_pixel_valid;
    assign o_pixel_index = r_o_pixel_index;
    assign o_pixel_red   = r_o_lvl[23:16];
    assign o_pixel_green = r_o_lvl[15:8];
    assign o_pixel_blue  = r_o_lvl[7:0];
    assign o_fade_done   = r_o_fade_done;
    assign o_last        = r_o_last;

endmodule

`default_nettype wire

FILE: hdl/led_fade_stepper_top.sv
// Top level of the LED fade stepper: controller plus datapath.
// A set word is taken while idle and gives no result word.
// A tick walks each LED through a memory read state and a step and write-back state, then
// closes in a final state; a step or the close can wait while the output register is stalled.
// A changed LED is held one step so the final word of a tick can be marked last.
// Reset clears the valid bits, so all levels and targets read as zero; the LED count resets to 16.
`default_nettype none

module led_fade_stepper_top import lfs_pkg::*; #(
    parameter int MAX_LEDS = 16
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output      logic                    o_stall,
    input  wire logic                    i_req_type,
    input  wire logic [3:0]              i_led_index,
    input  wire logic [7:0]              i_target_red,
    input  wire logic [7:0]              i_target_green,
    input  wire logic [7:0]              i_target_blue,
    output      logic                    o_valid,
    input  wire logic                    i_stall,
    output      logic                    o_pixel_valid,
    output      logic [3:0]              o_pixel_index,
    output      logic [7:0]              o_pixel_red,
    output      logic [7:0]              o_pixel_green,
    output      logic [7:0]              o_pixel_blue,
    output      logic                    o_fade_done,
    output      logic                    o_last,
    input  wire logic                    i_cfg_wr_en,
    input  wire logic [STRAND_LEN_W-1:0] i_cfg_wr_data
);

    localparam int IDX_W = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

    t_dp_cmd          dp_cmd;
    t_dp_status       dp_status;
    logic [IDX_W-1:0] rd_addr;

    lfs_ctrl #(
        .MAX_LEDS(MAX_LEDS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_req_type   (i_req_type),
        .i_led_index  (i_led_index),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_status     (dp_status),
        .o_cmd        (dp_cmd),
        .o_rd_addr    (rd_addr)
    );

    lfs_datapath #(
        .MAX_LEDS(MAX_LEDS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_status      (dp_status),
        .i_rd_addr     (rd_addr),
        .i_led_index   (i_led_index),
        .i_target_red  (i_target_red),
        .i_target_green(i_target_green),
        .i_target_blue (i_target_blue),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_pixel_valid (o_pixel_valid),
        .o_pixel_index (o_pixel_index),
        .o_pixel_red   (o_pixel_red),
        .o_pixel_green (o_pixel_green),
        .o_pixel_blue  (o_pixel_blue),
        .o_fade_done   (o_fade_done),
        .o_last        (o_last)
    );

endmodule

`default_nettype wire

FILE: sim/tb.sv
// Self-checking testbench for the LED fade stepper top level.
module tb import lfs_pkg::*; ();

    typedef struct packed {
        logic       pv;
        logic [3:0] idx;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       done;
        logic       is_last;
    } t_pixel;

    class pixel_scoreboard;
        logic [7:0] cur_level [16][3];
        logic [7:0] tgt_level [16][3];
        logic [STRAND_LEN_W-1:0] strand_len;
        t_pixel pending_pixels [$];
        int errors;

        function new();
            for (int i = 0; i < 16; i++) begin
                for (int k = 0; k < 3; k++) begin
                    cur_level[i][k] = 8'd0;
                    tgt_level[i][k] = 8'd0;
                end
            end
            strand_len = STRAND_LEN_RESET;
            errors = 0;
        endfunction

        function int pending();
            return pending_pixels.size();
        endfunction

        function logic [7:0] fade_step(logic [7:0] cur, logic [7:0] tgt);
            int c;
            int t;
            int inc;
            c = cur;
            t = tgt;
            inc = c / 31 + 1;
            if (c < t) begin
                if (c + inc > t) return tgt;
                return 8'(c + inc);
            end
            if (inc > c || c - inc < t) return tgt;
            return 8'(c - (inc / 2 + 1));
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("tb: mismatch: %s", msg);
        endtask

        function void note_word(logic req, logic [3:0] idx, logic [7:0] r, logic [7:0] g,
                                logic [7:0] b);
            t_pixel held;
            t_pixel px;
            bit have_held;
            bit changed;
            int n;
            if (req == REQ_SET) begin
                tgt_level[idx][0] = r;
                tgt_level[idx][1] = g;
                tgt_level[idx][2] = b;
                return;
            end
            n = (strand_len > 16) ? 16 : strand_len;
            have_held = 0;
            for (int i = 0; i < n; i++) begin
                changed = 0;
                for (int k = 0; k < 3; k++) begin
                    if (cur_level[i][k] != tgt_level[i][k]) begin
                        cur_level[i][k] = fade_step(cur_level[i][k], tgt_level[i][k]);
                        changed = 1;
                    end
                end
                if (changed) begin
                    if (have_held) pending_pixels.push_back(held);
                    held = '{pv: 1'b1, idx: 4'(i), red: cur_level[i][0],
                             green: cur_level[i][1], blue: cur_level[i][2],
                             done: 1'b0, is_last: 1'b0};
                    have_held = 1;
                end
            end
            if (have_held) begin
                held.is_last = 1'b1;
                pending_pixels.push_back(held);
            end else begin
                px = '0;
                px.done = 1'b1;
                px.is_last = 1'b1;
                pending_pixels.push_back(px);
            end
        endfunction

        task check_pixel(t_pixel got);
            t_pixel want;
            if (pending_pixels.size() == 0) begin
                report_mismatch("result word with no expected word waiting");
                return;
            end
            want = pending_pixels.pop_front();
            if (got.pv !== want.pv)
                report_mismatch($sformatf("pixel_valid %b, expected %b", got.pv, want.pv));
            if (got.idx !== want.idx)
                report_mismatch($sformatf("pixel_index %0d, expected %0d", got.idx, want.idx));
            if (got.red !== want.red)
                report_mismatch($sformatf("LED %0d red %0d, expected %0d",
                                          want.idx, got.red, want.red));
            if (got.green !== want.green)
                report_mismatch($sformatf("LED %0d green %0d, expected %0d",
                                          want.idx, got.green, want.green));
            if (got.blue !== want.blue)
                report_mismatch($sformatf("LED %0d blue %0d, expected %0d",
                                          want.idx, got.blue, want.blue));
            if (got.done !== want.done)
                report_mismatch($sformatf("fade_done %b, expected %b", got.done, want.done));
            if (got.is_last !== want.is_last)
                report_mismatch($sformatf("last %b, expected %b", got.is_last, want.is_last));
        endtask
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_stall;
    logic                    i_req_type;
    logic [3:0]              i_led_index;
    logic [7:0]              i_target_red;
    logic [7:0]              i_target_green;
    logic [7:0]              i_target_blue;
    logic                    o_valid;
    logic                    i_stall;
    logic                    o_pixel_valid;
    logic [3:0]              o_pixel_index;
    logic [7:0]              o_pixel_red;
    logic [7:0]              o_pixel_green;
    logic [7:0]              o_pixel_blue;
    logic                    o_fade_done;
    logic                    o_last;
    logic                    i_cfg_wr_en;
    logic [STRAND_LEN_W-1:0] i_cfg_wr_data;

    pixel_scoreboard sb;
    int send_idle_pct;
    int stall_pct;
    int hold_left;

    led_fade_stepper_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_req_type     (i_req_type),
        .i_led_index    (i_led_index),
        .i_target_red   (i_target_red),
        .i_target_green (i_target_green),
        .i_target_blue  (i_target_blue),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_pixel_valid  (o_pixel_valid),
        .o_pixel_index  (o_pixel_index),
        .o_pixel_red    (o_pixel_red),
        .o_pixel_green  (o_pixel_green),
        .o_pixel_blue   (o_pixel_blue),
        .o_fade_done    (o_fade_done),
        .o_last         (o_last),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("tb: failure");
        $finish;
    end

    // The hold-off counter lives here so the long stall is timed by the receiver itself.
    initial begin
        i_stall = 1'b0;
        forever @(negedge i_clk) begin
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else begin
                i_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_pixel('{pv: o_pixel_valid, idx: o_pixel_index, red: o_pixel_red,
                             green: o_pixel_green, blue: o_pixel_blue,
                             done: o_fade_done, is_last: o_last});
        end
    end

    task automatic send_word(logic req, logic [3:0] idx, logic [7:0] r, logic [7:0] g,
                             logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid        <= 1'b1;
        i_req_type     <= req;
        i_led_index    <= idx;
        i_target_red   <= r;
        i_target_green <= g;
        i_target_blue  <= b;
        do @(posedge i_clk); while (o_stall);
        sb.note_word(req, idx, r, g, b);
    endtask

    function automatic logic [7:0] pick_level();
        case ($urandom_range(0, 3))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic random_word();
        logic       req;
        logic [3:0] idx;
        int         lim;
        lim = (sb.strand_len > 16) ? 16 : ((sb.strand_len == 0) ? 1 : sb.strand_len);
        req = ($urandom_range(0, 99) < 30) ? REQ_SET : REQ_TICK;
        idx = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                          : 4'($urandom_range(0, lim - 1));
        send_word(req, idx, pick_level(), pick_level(), pick_level());
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_strand_len(logic [STRAND_LEN_W-1:0] value);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.strand_len = value;
    endtask

    task automatic run_phase(int idle, int stall, logic [STRAND_LEN_W-1:0] count, int words);
        wait_drained();
        write_strand_len(count);
        send_idle_pct = idle;
        stall_pct = stall;
        repeat (words) random_word();
    endtask

    initial begin
        sb = new();
        send_idle_pct = 0;
        stall_pct = 0;
        hold_left = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_req_type = REQ_SET;
        i_led_index = 4'd0;
        i_target_red = 8'd0;
        i_target_green = 8'd0;
        i_target_blue = 8'd0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: idle tick, rising fades with clamping, falling fades, unchanged target.
        send_word(REQ_TICK, 4'd0, 8'd0, 8'd0, 8'd0);
        send_word(REQ_SET, 4'd0, 8'd255, 8'd255, 8'd255);
        send_word(REQ_SET, 4'd15, 8'd255, 8'd0, 8'd128);
        send_word(REQ_SET, 4'd9, 8'd31, 8'd62, 8'd1);
        repeat (6) send_word(REQ_TICK, 4'd15, 8'd255, 8'd255, 8'd255);
        send_word(REQ_SET, 4'd0, 8'd0, 8'd0, 8'd0);
        send_word(REQ_SET, 4'd15, 8'd0, 8'd255, 8'd0);
        send_word(REQ_SET, 4'd9, 8'd30, 8'd61, 8'd0);
        repeat (7) send_word(REQ_TICK, 4'd0, 8'd0, 8'd0, 8'd0);
        send_word(REQ_SET, 4'd5, 8'd0, 8'd0, 8'd0);
        send_word(REQ_TICK, 4'd5, 8'd0, 8'd0, 8'd0);

        repeat (100) random_word();
        run_phase(86, 0, 5'd1, 60);
        run_phase(0, 86, 5'd0, 30);
        run_phase(9, 9, 5'd31, 100);
        run_phase(86, 86, 5'd5, 60);
        run_phase(0, 0, 5'd17, 40);

        // Receiver held off while the sender keeps offering words.
        wait_drained();
        write_strand_len(5'd16);
        send_idle_pct = 0;
        stall_pct = 0;
        hold_left = 400;
        repeat (40) random_word();

        run_phase(0, 0, 5'($urandom_range(1, 16)), 100);

        wait_drained();
        repeat (60) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
